### rtl/scr_pkg.sv
`timescale 1ns / 1ps

package scr_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  // status codes of a result
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_RANGE      = 2'd1;
  localparam logic [1:0] ST_REPEAT     = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  localparam int unsigned LETTERS = 26;
  localparam logic [7:0] CHAR_LO = 8'h61;
  localparam logic [7:0] CHAR_HI = 8'h7a;
  localparam logic [7:0] CHAR_NL = 8'h0a;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic [1:0] status;
    logic       truncated;
    logic       last;
  } out_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    OP_STATUS,
    OP_PUSH,
    OP_FLUSH
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] ch;
    logic [1:0] status;
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_NL
  } back_state_e;

endpackage

### rtl/substitution_cipher_line_reverse_top.sv
`timescale 1ns / 1ps
// a status result is stored in the op queue and then in the result queue before the result ports show it
// rate: one item per cycle while the op queue has room; the back stores one data byte per cycle when idle
// a flush holds the back through its emit and newline states, with one line store read per character
// reset: asynchronous, active low; clears seen masks, pair count, mode, line length and queues
// after reset the table is incomplete and the map entries are unwritten

module substitution_cipher_line_reverse_top #(
  parameter int unsigned LINE_DEPTH = 63
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input queue side
  input  logic          push,
  output logic          full,
  input  scr_pkg::in_t  in_data_i,
  // result queue side
  output logic          empty,
  input  logic          pop,
  output scr_pkg::out_t out_data_o,
  // cipher mode register
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);

  scr_pkg::op_t  op_in, op_out;
  logic          op_full, op_empty, op_pop;
  logic          in_acc;
  scr_pkg::out_t res_data;
  logic          res_push, res_full;

  // the mode register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  // an input transfer goes straight into the op queue
  assign full   = op_full;
  assign in_acc = push && !op_full;

  // front: table loading, checks and byte substitution
  scr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (in_acc),
    .in_data_i  (in_data_i),
    .op_o       (op_in)
  );

  // short queue that lets the front run ahead of a flush
  scr_fifo #(
    .DEPTH(4),
    .T    (scr_pkg::op_t)
  ) u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_acc),
    .data_i (op_in),
    .full_o (op_full),
    .pop_i  (op_pop),
    .data_o (op_out),
    .empty_o(op_empty)
  );

  // back: line store and reversed flush
  scr_back #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_empty_i(op_empty),
    .op_i      (op_out),
    .op_pop_o  (op_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (res_data)
  );

  // result queue parts the back from the consumer
  scr_fifo #(
    .DEPTH(2),
    .T    (scr_pkg::out_t)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_data),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule

### rtl/scr_fifo.sv
`timescale 1ns / 1ps

module scr_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type         T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/scr_front.sv
`timescale 1ns / 1ps

module scr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic          cfg_data_i,
  input  logic          acc_i,
  input  scr_pkg::in_t  in_data_i,
  output scr_pkg::op_t  op_o
);

  logic [4:0]  fwd_q [scr_pkg::LETTERS];
  logic [4:0]  inv_q [scr_pkg::LETTERS];
  logic [25:0] plain_seen_q, plain_seen_d;
  logic [25:0] cipher_seen_q, cipher_seen_d;
  logic [4:0]  pair_count_q, pair_count_d;
  logic        mode_q;

  logic [7:0]  a_off, b_off;
  logic [4:0]  pa, pb;
  logic        a_letter, b_letter;
  logic        table_ready;
  logic        map_wr;
  logic [4:0]  map_val;
  logic [7:0]  mapped;

  assign a_letter    = (in_data_i.byte_a >= scr_pkg::CHAR_LO) &&
                       (in_data_i.byte_a <= scr_pkg::CHAR_HI);
  assign b_letter    = (in_data_i.byte_b >= scr_pkg::CHAR_LO) &&
                       (in_data_i.byte_b <= scr_pkg::CHAR_HI);
  assign a_off       = in_data_i.byte_a - scr_pkg::CHAR_LO;
  assign b_off       = in_data_i.byte_b - scr_pkg::CHAR_LO;
  assign pa          = a_off[4:0];
  assign pb          = b_off[4:0];
  assign table_ready = (pair_count_q == 5'(scr_pkg::LETTERS));

  // substitution through the selected direction of the table
  assign map_val = mode_q ? inv_q[pa] : fwd_q[pa];
  assign mapped  = a_letter ? (scr_pkg::CHAR_LO + {3'b000, map_val}) : in_data_i.byte_a;

  always_comb begin
    plain_seen_d  = plain_seen_q;
    cipher_seen_d = cipher_seen_q;
    pair_count_d  = pair_count_q;
    map_wr        = 1'b0;
    op_o.kind     = scr_pkg::OP_STATUS;
    op_o.ch       = in_data_i.byte_a;
    op_o.status   = scr_pkg::ST_OK;
    unique case (in_data_i.command)
      scr_pkg::CMD_CLEAR: begin
        plain_seen_d  = '0;
        cipher_seen_d = '0;
        pair_count_d  = '0;
      end
      scr_pkg::CMD_LOAD: begin
        if (!a_letter || !b_letter) begin
          op_o.status = scr_pkg::ST_RANGE;
        end else if (plain_seen_q[pa] || cipher_seen_q[pb]) begin
          op_o.status = scr_pkg::ST_REPEAT;
        end else begin
          plain_seen_d[pa]  = 1'b1;
          cipher_seen_d[pb] = 1'b1;
          pair_count_d      = pair_count_q + 5'd1;
          map_wr            = 1'b1;
        end
      end
      scr_pkg::CMD_DATA: begin
        if (!table_ready) begin
          op_o.status = scr_pkg::ST_INCOMPLETE;
        end else if (in_data_i.byte_a == scr_pkg::CHAR_NL) begin
          op_o.kind = scr_pkg::OP_FLUSH;
        end else begin
          op_o.kind = scr_pkg::OP_PUSH;
          op_o.ch   = mapped;
        end
      end
      scr_pkg::CMD_END: begin
        op_o.kind = scr_pkg::OP_FLUSH;
      end
      default: begin
        op_o.kind = scr_pkg::OP_FLUSH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plain_seen_q  <= '0;
      cipher_seen_q <= '0;
      pair_count_q  <= '0;
      mode_q        <= 1'b0;
    end else begin
      if (acc_i) begin
        plain_seen_q  <= plain_seen_d;
        cipher_seen_q <= cipher_seen_d;
        pair_count_q  <= pair_count_d;
      end
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && map_wr) begin
      fwd_q[pa] <= pb;
      inv_q[pb] <= pa;
    end
  end

endmodule

### rtl/scr_back.sv
`timescale 1ns / 1ps

module scr_back #(
  parameter int unsigned LINE_DEPTH = 63
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_empty_i,
  input  scr_pkg::op_t  op_i,
  output logic          op_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output scr_pkg::out_t res_o
);

  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [7:0]  line_mem [LINE_DEPTH];
  logic [7:0]  rd_data_q;

  scr_pkg::back_state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;

  logic          mem_wr;
  logic          mem_rd;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] len_m1, cnt_m1;
  logic          line_full;

  assign len_m1    = len_q - LW'(1);
  assign cnt_m1    = cnt_q - LW'(1);
  assign line_full = (len_q == LW'(LINE_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scr_pkg::BK_IDLE: begin
        if (!op_empty_i && op_i.kind == scr_pkg::OP_FLUSH) begin
          state_d = (len_q == '0) ? scr_pkg::BK_NL : scr_pkg::BK_EMIT;
        end
      end
      scr_pkg::BK_EMIT: begin
        if (!res_full_i && cnt_q == '0) begin
          state_d = scr_pkg::BK_NL;
        end
      end
      scr_pkg::BK_NL: begin
        if (!res_full_i) begin
          state_d = scr_pkg::BK_IDLE;
        end
      end
      default: state_d = scr_pkg::BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_pop_o   = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    mem_wr     = 1'b0;
    mem_rd     = 1'b0;
    rd_addr    = len_m1[AW-1:0];
    len_d      = len_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    unique case (state_q)
      scr_pkg::BK_IDLE: begin
        if (!op_empty_i) begin
          unique case (op_i.kind)
            scr_pkg::OP_STATUS: begin
              res_o.status = op_i.status;
              res_o.last   = 1'b1;
              res_push_o   = !res_full_i;
              op_pop_o     = !res_full_i;
            end
            scr_pkg::OP_PUSH: begin
              op_pop_o = 1'b1;
              if (line_full) begin
                ovf_d = 1'b1;
              end else begin
                mem_wr = 1'b1;
                len_d  = len_q + LW'(1);
              end
            end
            scr_pkg::OP_FLUSH: begin
              op_pop_o = 1'b1;
              if (len_q != '0) begin
                mem_rd = 1'b1;
                cnt_d  = len_m1;
              end
            end
            default: op_pop_o = 1'b1;
          endcase
        end
      end
      scr_pkg::BK_EMIT: begin
        res_o.out_char   = rd_data_q;
        res_o.char_valid = 1'b1;
        res_o.truncated  = ovf_q;
        res_push_o       = !res_full_i;
        if (!res_full_i && cnt_q != '0) begin
          mem_rd  = 1'b1;
          rd_addr = cnt_m1[AW-1:0];
          cnt_d   = cnt_m1;
        end
      end
      scr_pkg::BK_NL: begin
        res_o.out_char   = scr_pkg::CHAR_NL;
        res_o.char_valid = 1'b1;
        res_o.truncated  = ovf_q;
        res_o.last       = 1'b1;
        res_push_o       = !res_full_i;
        if (!res_full_i) begin
          len_d = '0;
          ovf_d = 1'b0;
        end
      end
      default: begin
        res_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scr_pkg::BK_IDLE;
      len_q   <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      line_mem[len_q[AW-1:0]] <= op_i.ch;
    end
    if (mem_rd) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(LINE_DEPTH))
    else $error("line length beyond depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> line_full)
    else $error("overflow flag set while line store has room");

  a_cnt_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scr_pkg::BK_EMIT) |-> (cnt_q < len_q))
    else $error("flush index outside stored line");

  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scr_pkg::BK_NL && !res_full_i) |=> (len_q == '0 && !ovf_q))
    else $error("line not emptied after newline transfer");
`endif

endmodule

### tb/tb_substitution_cipher_line_reverse_top.sv
`timescale 1ns / 1ps

module tb_substitution_cipher_line_reverse_top;

  localparam int LINE_DEPTH = 63;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 16;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  scr_pkg::in_t in_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  scr_pkg::out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i = 1'b0;

  substitution_cipher_line_reverse_top #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // commands waiting for their transfer, and results predicted but not yet seen
  scr_pkg::in_t  cmd_backlog[$];
  scr_pkg::out_t predicted_out[$];
  int   mismatch_cnt = 0;
  int unsigned cyc = 0;

  // shadow of the cipher state
  logic [4:0] fwd_map[scr_pkg::LETTERS];
  logic [4:0] inv_map[scr_pkg::LETTERS];
  logic [scr_pkg::LETTERS-1:0] plain_seen = '0;
  logic [scr_pkg::LETTERS-1:0] cipher_seen = '0;
  int pairs_loaded = 0;
  logic [7:0] line_buf[LINE_DEPTH];
  int line_len = 0;
  logic line_ovf = 1'b0;
  logic mode_q = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  // breaks at random with a chance of 22 in a hundred, but never while the cycle count modulo 1600 is 1000 or more
  function automatic bit take_break(int unsigned c);
    if ((c % 1600) >= 1000) return 1'b0;
    return $urandom_range(99) < 22;
  endfunction

  function automatic bit is_lower(logic [7:0] c);
    return c >= scr_pkg::CHAR_LO && c <= scr_pkg::CHAR_HI;
  endfunction

  task automatic note_status(input logic [1:0] st);
    predicted_out.push_back(scr_pkg::out_t'{8'h00, 1'b0, st, 1'b0, 1'b1});
  endtask

  // stored line comes out newest first, then a newline closes it
  task automatic flush_line();
    for (int i = line_len - 1; i >= 0; i--)
      predicted_out.push_back(scr_pkg::out_t'{line_buf[i], 1'b1, scr_pkg::ST_OK,
                                              line_ovf, 1'b0});
    predicted_out.push_back(scr_pkg::out_t'{scr_pkg::CHAR_NL, 1'b1, scr_pkg::ST_OK,
                                            line_ovf, 1'b1});
    line_len = 0;
    line_ovf = 1'b0;
  endtask

  task automatic cipher_predict(input scr_pkg::in_t it);
    logic [4:0] pa;
    logic [4:0] pb;
    logic [4:0] ci;
    logic [7:0] ch;
    case (it.command)
      scr_pkg::CMD_CLEAR: begin
        plain_seen = '0;
        cipher_seen = '0;
        pairs_loaded = 0;
        note_status(scr_pkg::ST_OK);
      end
      scr_pkg::CMD_LOAD: begin
        if (!is_lower(it.byte_a) || !is_lower(it.byte_b)) begin
          note_status(scr_pkg::ST_RANGE);
        end else begin
          pa = 5'(it.byte_a - scr_pkg::CHAR_LO);
          pb = 5'(it.byte_b - scr_pkg::CHAR_LO);
          if (plain_seen[pa] || cipher_seen[pb]) begin
            note_status(scr_pkg::ST_REPEAT);
          end else begin
            plain_seen[pa] = 1'b1;
            cipher_seen[pb] = 1'b1;
            fwd_map[pa] = pb;
            inv_map[pb] = pa;
            pairs_loaded++;
            note_status(scr_pkg::ST_OK);
          end
        end
      end
      scr_pkg::CMD_DATA: begin
        if (pairs_loaded != scr_pkg::LETTERS) begin
          note_status(scr_pkg::ST_INCOMPLETE);
        end else if (it.byte_a == scr_pkg::CHAR_NL) begin
          flush_line();
        end else if (line_len < LINE_DEPTH) begin
          ch = it.byte_a;
          // only lower case letters go through the table
          if (is_lower(ch)) begin
            ci = 5'(ch - scr_pkg::CHAR_LO);
            ch = scr_pkg::CHAR_LO + {3'b000, (mode_q ? inv_map[ci] : fwd_map[ci])};
          end
          line_buf[line_len] = ch;
          line_len++;
        end else begin
          line_ovf = 1'b1;
        end
      end
      default: flush_line();
    endcase
  endtask

  task automatic check_result(input scr_pkg::out_t got);
    scr_pkg::out_t want;
    if (predicted_out.size() == 0) begin
      mismatch_cnt++;
      $display("%0t ns: unpredicted result char %02h valid %b status %0d trunc %b last %b",
               $time, got.out_char, got.char_valid, got.status, got.truncated, got.last);
    end else begin
      want = predicted_out.pop_front();
      if (got !== want) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 100)
          $display({"%0t ns: expected char %02h valid %b status %0d trunc %b last %b,",
                    " actual char %02h valid %b status %0d trunc %b last %b"},
                   $time, want.out_char, want.char_valid, want.status, want.truncated,
                   want.last, got.out_char, got.char_valid, got.status, got.truncated,
                   got.last);
      end
    end
  endtask

  // input side: the head of the backlog is on the port until its transfer
  always @(posedge clk_i or negedge rst_ni) begin : cmd_driver
    logic moved;
    if (!rst_ni) begin
      push <= 1'b0;
      in_data_i <= '0;
    end else begin
      moved = push && !full;
      if (moved)
        cipher_predict(cmd_backlog.pop_front());
      // a stalled push is held as it is
      if (moved || !push) begin
        if (cmd_backlog.size() != 0 && !take_break(cyc)) begin
          push <= 1'b1;
          in_data_i <= cmd_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side: pop stalls at random, every transfer is checked in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        check_result(out_data_o);
      pop <= !take_break(cyc);
    end
  end

  task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] a, input logic [7:0] b);
    cmd_backlog.push_back(scr_pkg::in_t'{cmd, a, b});
  endtask

  function automatic logic [7:0] non_letter();
    if ($urandom_range(1)) return 8'($urandom_range(96));
    return 8'($urandom_range(255, 123));
  endfunction

  // loads n_pairs of a fresh random table, with bad pairs mixed in now and then
  task automatic queue_table(input int n_pairs, input int noise_pct);
    int unsigned po[scr_pkg::LETTERS];
    int unsigned co[scr_pkg::LETTERS];
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < scr_pkg::LETTERS; i++) begin
      po[i] = i;
      co[i] = i;
    end
    for (int i = scr_pkg::LETTERS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = po[i]; po[i] = po[j]; po[j] = t;
      j = $urandom_range(i);
      t = co[i]; co[i] = co[j]; co[j] = t;
    end
    for (int i = 0; i < n_pairs; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        if (i > 0 && $urandom_range(1))
          queue_cmd(scr_pkg::CMD_LOAD, 8'(scr_pkg::CHAR_LO + po[$urandom_range(i - 1)]),
                    8'(scr_pkg::CHAR_LO + $urandom_range(25)));
        else if ($urandom_range(1))
          queue_cmd(scr_pkg::CMD_LOAD, non_letter(), 8'($urandom_range(255)));
        else
          queue_cmd(scr_pkg::CMD_LOAD, 8'(scr_pkg::CHAR_LO + $urandom_range(25)),
                    non_letter());
      end
      queue_cmd(scr_pkg::CMD_LOAD, 8'(scr_pkg::CHAR_LO + po[i]),
                8'(scr_pkg::CHAR_LO + co[i]));
    end
  endtask

  // mostly letters, some spaces and arbitrary bytes, closed by newline or end of input
  task automatic queue_line(input int len, input bit by_end);
    int unsigned r;
    logic [7:0] a;
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 75) a = 8'(scr_pkg::CHAR_LO + $urandom_range(25));
      else if (r < 88) a = 8'h20;
      else a = 8'($urandom_range(255));
      queue_cmd(scr_pkg::CMD_DATA, a, 8'($urandom_range(255)));
    end
    if (by_end)
      queue_cmd(scr_pkg::CMD_END, 8'($urandom_range(255)), 8'($urandom_range(255)));
    else
      queue_cmd(scr_pkg::CMD_DATA, scr_pkg::CHAR_NL, 8'($urandom_range(255)));
  endtask

  // wait for every transfer and result, then let the front settle
  task automatic drain();
    while (cmd_backlog.size() != 0 || push || predicted_out.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  initial begin : stimulus
    int random_cnt;
    int len;
    int unsigned r;
    random_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_mode(1'b0);

    // directed: empty table, bad pairs, repeats, clear, then edge bytes through a full table
    @(negedge clk_i);
    queue_cmd(scr_pkg::CMD_DATA, 8'h61, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, scr_pkg::CHAR_NL, 8'hff);
    queue_cmd(scr_pkg::CMD_END, 8'h00, 8'h00);
    queue_cmd(scr_pkg::CMD_LOAD, 8'h60, 8'h61);
    queue_cmd(scr_pkg::CMD_LOAD, 8'h61, 8'h7b);
    queue_cmd(scr_pkg::CMD_LOAD, 8'hff, 8'h00);
    queue_cmd(scr_pkg::CMD_LOAD, 8'h61, 8'h7a);
    queue_cmd(scr_pkg::CMD_LOAD, 8'h61, 8'h62);
    queue_cmd(scr_pkg::CMD_LOAD, 8'h63, 8'h7a);
    queue_cmd(scr_pkg::CMD_CLEAR, 8'hff, 8'hff);
    queue_table(scr_pkg::LETTERS, 0);
    queue_cmd(scr_pkg::CMD_LOAD, 8'h61, 8'h61);
    queue_cmd(scr_pkg::CMD_DATA, 8'h00, 8'hff);
    queue_cmd(scr_pkg::CMD_DATA, 8'hff, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, 8'h61, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, 8'h7a, 8'hff);
    queue_cmd(scr_pkg::CMD_DATA, 8'h7b, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, 8'h60, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, scr_pkg::CHAR_NL, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, scr_pkg::CHAR_NL, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, 8'h71, 8'h00);
    queue_cmd(scr_pkg::CMD_END, 8'hff, 8'hff);
    drain();

    // same table, decrypt direction
    set_mode(1'b1);
    @(negedge clk_i);
    queue_cmd(scr_pkg::CMD_DATA, 8'h61, 8'h00);
    queue_cmd(scr_pkg::CMD_DATA, 8'h7a, 8'h00);
    queue_cmd(scr_pkg::CMD_END, 8'h00, 8'h00);

    // random: mostly clean table loads followed by lines, some broken loads and noise
    while (random_cnt < RANDOM_ITEMS) begin
      drain();
      set_mode(1'($urandom_range(1)));
      @(negedge clk_i);
      r = $urandom_range(9);
      queue_cmd(scr_pkg::CMD_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)));
      if (r == 0) begin
        // table left short: data is refused, end of input still flushes
        queue_table($urandom_range(25, 1), 10);
        queue_line($urandom_range(6), 1'b0);
        queue_line(0, 1'b1);
      end else begin
        queue_table(scr_pkg::LETTERS, (r < 4) ? 15 : 0);
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(4) == 0) len = $urandom_range(72, 60);
          else len = $urandom_range(12);
          if ($urandom_range(9) == 0)
            queue_cmd(2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
          queue_line(len, $urandom_range(3) == 0);
        end
      end
      random_cnt += cmd_backlog.size();
    end
    drain();

    if (mismatch_cnt == 0) begin
      $display("tb_substitution_cipher_line_reverse_top: clean");
    end else begin
      $display("tb_substitution_cipher_line_reverse_top: errors");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("tb_substitution_cipher_line_reverse_top: errors");
    $finish;
  end

endmodule
